FILE: hdl/sdlcd_pkg.sv
// shared constants, types and state codes for the signed decimal to lcd nibble converter
package sdlcd_pkg;

  // input word width and number of decimal digits kept
  localparam int VALUE_WIDTH = 32;
  localparam int MAX_DIGITS  = 10;

  // derived widths
  localparam int BCD_W  = 4 * MAX_DIGITS;
  localparam int CNT_W  = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam int DIG_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  // queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // character codes
  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'h2D;

  // one classified word: sign flag and unsigned magnitude
  typedef struct packed {
    logic                   neg;
    logic [VALUE_WIDTH-1:0] mag;
  } item_t;

  // write side of the queue
  typedef struct packed {
    logic  push;
    item_t item;
  } q_wr_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_EMIT
  } back_state_t;

endpackage

FILE: hdl/sdlcd_front.sv
// front end: accepts a signed word and splits it into sign and magnitude
module sdlcd_front (
  input  logic                                    in_push,
  input  logic signed [sdlcd_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    in_full,
  input  logic                                    q_full,
  output sdlcd_pkg::q_wr_t                        q_wr
);

  logic                             neg;
  logic [sdlcd_pkg::VALUE_WIDTH-1:0] raw;
  logic [sdlcd_pkg::VALUE_WIDTH-1:0] mag;

  // sign test and two's complement magnitude, most negative value stays unsigned
  always_comb begin
    raw = in_value;
    neg = raw[sdlcd_pkg::VALUE_WIDTH-1];
    mag = neg ? (~raw + 1'b1) : raw;
  end

  // accept whenever the queue has room
  assign in_full          = q_full;
  assign q_wr.push        = in_push && !q_full;
  assign q_wr.item.neg    = neg;
  assign q_wr.item.mag    = mag;

endmodule

FILE: hdl/sdlcd_queue.sv
// short queue of classified words between front and back end
module sdlcd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  sdlcd_pkg::q_wr_t  q_wr,
  output logic              q_full,
  input  logic              q_pop,
  output logic              q_empty,
  output sdlcd_pkg::item_t  q_item
);

  sdlcd_pkg::item_t                mem_r [sdlcd_pkg::QDEPTH];
  logic [sdlcd_pkg::QPTR_W-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [sdlcd_pkg::QPTR_W-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [sdlcd_pkg::QCNT_W-1:0]    cnt_r, cnt_nxt;
  logic                            do_wr, do_rd;

  assign q_full  = (cnt_r == sdlcd_pkg::QCNT_W'(sdlcd_pkg::QDEPTH));
  assign q_empty = (cnt_r == '0);
  assign q_item  = mem_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    do_wr      = q_wr.push && !q_full;
    do_rd      = q_pop && !q_empty;
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == sdlcd_pkg::QPTR_W'(sdlcd_pkg::QDEPTH - 1)) ? '0
                                                                           : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == sdlcd_pkg::QPTR_W'(sdlcd_pkg::QDEPTH - 1)) ? '0
                                                                           : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= q_wr.item;
    end
  end

endmodule

FILE: hdl/sdlcd_back.sv
// back end: shift-add-3 binary to bcd, then character and nibble sequencing
module sdlcd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  sdlcd_pkg::item_t  q_item,
  output logic              q_pop,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [3:0]        out_nibble,
  output logic              out_final_transfer
);

  sdlcd_pkg::back_state_t             state_r, state_nxt;
  logic [sdlcd_pkg::VALUE_WIDTH-1:0]  mag_r, mag_nxt;
  logic [sdlcd_pkg::BCD_W-1:0]        bcd_r, bcd_nxt;
  logic                               ovf_r, ovf_nxt;
  logic                               sgn_r, sgn_nxt;
  logic [sdlcd_pkg::CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [sdlcd_pkg::DIG_W-1:0]        idx_r, idx_nxt;
  logic                               half_r, half_nxt;
  logic                               ovalid_r, ovalid_nxt;
  logic [3:0]                         onib_r, onib_nxt;
  logic                               ofin_r, ofin_nxt;

  // leading digit position, taken once conversion has settled
  logic                               lead_load_r;

  logic [sdlcd_pkg::BCD_W-1:0]        adj;
  logic [sdlcd_pkg::DIG_W-1:0]        lead;
  logic [7:0]                         ch;
  logic                               adv;

  assign out_empty          = !ovalid_r;
  assign out_nibble         = onib_r;
  assign out_final_transfer = ofin_r;

  // add 3 to every bcd digit of 5 or more before the shift
  always_comb begin
    adj = bcd_r;
    for (int i = 0; i < sdlcd_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  // highest nonzero digit after conversion, all digits when the value overflowed
  always_comb begin
    lead = '0;
    for (int i = 0; i < sdlcd_pkg::MAX_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) begin
        lead = sdlcd_pkg::DIG_W'(i);
      end
    end
    if (ovf_r) begin
      lead = sdlcd_pkg::DIG_W'(sdlcd_pkg::MAX_DIGITS - 1);
    end
  end

  // current character: pending minus sign or the digit at idx
  assign ch  = sgn_r ? sdlcd_pkg::ASCII_MINUS
                     : (sdlcd_pkg::ASCII_ZERO + {4'd0, bcd_r[4*idx_r +: 4]});
  assign adv = !ovalid_r || out_pop;

  // sequencer next state and outputs
  always_comb begin
    state_nxt  = state_r;
    mag_nxt    = mag_r;
    bcd_nxt    = bcd_r;
    ovf_nxt    = ovf_r;
    sgn_nxt    = sgn_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    half_nxt   = half_r;
    onib_nxt   = onib_r;
    ofin_nxt   = ofin_r;
    ovalid_nxt = ovalid_r && !out_pop;
    q_pop      = 1'b0;
    unique case (state_r)
      sdlcd_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          mag_nxt   = q_item.mag;
          sgn_nxt   = q_item.neg;
          bcd_nxt   = '0;
          ovf_nxt   = 1'b0;
          cnt_nxt   = sdlcd_pkg::CNT_W'(sdlcd_pkg::VALUE_WIDTH - 1);
          state_nxt = sdlcd_pkg::BK_CONV;
        end
      end
      sdlcd_pkg::BK_CONV: begin
        bcd_nxt = {adj[sdlcd_pkg::BCD_W-2:0], mag_r[sdlcd_pkg::VALUE_WIDTH-1]};
        ovf_nxt = ovf_r | adj[sdlcd_pkg::BCD_W-1];
        mag_nxt = {mag_r[sdlcd_pkg::VALUE_WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          half_nxt  = 1'b0;
          state_nxt = sdlcd_pkg::BK_EMIT;
        end
      end
      sdlcd_pkg::BK_EMIT: begin
        if (lead_load_r) begin
          idx_nxt = lead;
        end else if (adv) begin
          ovalid_nxt = 1'b1;
          if (!half_r) begin
            onib_nxt = ch[7:4];
            ofin_nxt = 1'b0;
            half_nxt = 1'b1;
          end else begin
            onib_nxt = ch[3:0];
            ofin_nxt = !sgn_r && (idx_r == '0);
            half_nxt = 1'b0;
            if (sgn_r) begin
              sgn_nxt = 1'b0;
            end else if (idx_r == '0) begin
              state_nxt = sdlcd_pkg::BK_IDLE;
            end else begin
              idx_nxt = idx_r - 1'b1;
            end
          end
        end
      end
      default: begin
        state_nxt = sdlcd_pkg::BK_IDLE;
      end
    endcase
    // digit index is cleared on the last conversion step; the leading digit is loaded once lead_load_r is set
    if (state_r == sdlcd_pkg::BK_CONV && cnt_r == '0) begin
      idx_nxt = '0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sdlcd_pkg::BK_IDLE;
      ovalid_r    <= 1'b0;
      lead_load_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ovalid_r    <= ovalid_nxt;
      lead_load_r <= (state_r == sdlcd_pkg::BK_CONV) && (cnt_r == '0);
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    ovf_r  <= ovf_nxt;
    cnt_r  <= cnt_nxt;
    half_r <= half_nxt;
    idx_r  <= idx_nxt;
    sgn_r  <= sgn_nxt;
    onib_r <= onib_nxt;
    ofin_r <= ofin_nxt;
  end

endmodule

FILE: hdl/signed_decimal_to_lcd_nibbles.sv
// top level of the signed decimal to lcd nibble converter
//
//   channel  ports                                  direction
//   input    in_push, in_full, in_value[31:0]       word in, signed
//   result   out_pop, out_empty, out_nibble[3:0],   word out, one nibble
//            out_final_transfer
//
// a word is dequeued, converted by the shift-add-3 loop, and its leading digit
// is picked; then each character is sent as two nibbles, high nibble first.
// a 2-entry queue takes new words while the back end is busy.
// reset is synchronous, active low, and empties the queue and output register.
// pop held low stalls only the nibble sequencer; the queue accepts until full.
module signed_decimal_to_lcd_nibbles (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_push,
  output logic                                    in_full,
  input  logic signed [sdlcd_pkg::VALUE_WIDTH-1:0] in_value,
  output logic                                    out_empty,
  input  logic                                    out_pop,
  output logic [3:0]                              out_nibble,
  output logic                                    out_final_transfer
);

  sdlcd_pkg::q_wr_t  q_wr;
  sdlcd_pkg::item_t  q_item;
  logic              q_full;
  logic              q_empty;
  logic              q_pop;

  // sign and magnitude split
  sdlcd_front u_front (
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_full   (q_full),
    .q_wr     (q_wr)
  );

  // decoupling queue
  sdlcd_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_wr    (q_wr),
    .q_full  (q_full),
    .q_pop   (q_pop),
    .q_empty (q_empty),
    .q_item  (q_item)
  );

  // conversion and nibble output
  sdlcd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_item             (q_item),
    .q_pop              (q_pop),
    .out_empty          (out_empty),
    .out_pop            (out_pop),
    .out_nibble         (out_nibble),
    .out_final_transfer (out_final_transfer)
  );

endmodule

FILE: dv/tb_top.sv
// testbench for the signed decimal to lcd nibble converter: random and corner words, scoreboard
`timescale 1ns / 100ps

module tb_top;

  // run length and timing knobs
  localparam int RANDOM_WORDS = 140;
  localparam int CALM_WORDS   = 30;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 80;
  localparam int CYCLE_LIMIT  = 400000;

  // one expected nibble transfer
  typedef struct packed {
    logic [3:0] nibble;
    logic       final_transfer;
  } nibble_xfer_t;

  // expected nibble stream, built from each accepted word
  class nibble_ledger;
    nibble_xfer_t pending_nibbles[$];
    int           errors = 0;

    // split one character into its two transfers, high nibble first
    function void push_char(input logic [7:0] ch, input logic last);
      nibble_xfer_t x;
      x.nibble         = ch[7:4];
      x.final_transfer = 1'b0;
      pending_nibbles.push_back(x);
      x.nibble         = ch[3:0];
      x.final_transfer = last;
      pending_nibbles.push_back(x);
    endfunction

    // decimal conversion of an accepted word into expected transfers
    function void note_value(input logic [sdlcd_pkg::VALUE_WIDTH-1:0] raw);
      logic                              neg;
      logic [sdlcd_pkg::VALUE_WIDTH-1:0] mag;
      logic [sdlcd_pkg::VALUE_WIDTH-1:0] rem;
      logic [7:0]                        digit_chars [sdlcd_pkg::MAX_DIGITS];
      int                                ndig;
      neg  = raw[sdlcd_pkg::VALUE_WIDTH-1];
      mag  = neg ? (~raw + 1'b1) : raw;
      ndig = 0;
      if (mag == '0) begin
        digit_chars[0] = sdlcd_pkg::ASCII_ZERO;
        ndig = 1;
      end else begin
        // least significant digit first, at most MAX_DIGITS kept
        while (mag != '0 && ndig < sdlcd_pkg::MAX_DIGITS) begin
          rem = mag % 10;
          digit_chars[ndig] = sdlcd_pkg::ASCII_ZERO + rem[7:0];
          mag = mag / 10;
          ndig++;
        end
      end
      if (neg) push_char(sdlcd_pkg::ASCII_MINUS, 1'b0);
      for (int i = ndig - 1; i >= 0; i--) push_char(digit_chars[i], i == 0);
    endfunction

    // compare one popped transfer with the oldest expectation
    function void check_nibble(input logic [3:0] nib, input logic fin);
      nibble_xfer_t x;
      if (pending_nibbles.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual nibble %h final %b",
                 $time, nib, fin);
        errors++;
        return;
      end
      x = pending_nibbles.pop_front();
      if (nib !== x.nibble) begin
        $display("%0t: nibble mismatch, expected %h, actual %h", $time, x.nibble, nib);
        errors++;
      end
      if (fin !== x.final_transfer) begin
        $display("%0t: final_transfer mismatch, expected %b, actual %b",
                 $time, x.final_transfer, fin);
        errors++;
      end
    endfunction

    function int pending();
      return pending_nibbles.size();
    endfunction
  endclass

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_push = 1'b0;
  logic                              in_full;
  logic [sdlcd_pkg::VALUE_WIDTH-1:0] in_value = '0;
  logic                              out_empty;
  logic                              out_pop = 1'b0;
  logic [3:0]                        out_nibble;
  logic                              out_final_transfer;

  nibble_ledger ledger = new();
  bit           calm = 1'b0;
  int           cycle_count = 0;

  // corner words: zero, digit boundaries, extremes, most negative value
  logic [31:0] corner_values [20] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    -32'sd100, 32'd12345, -32'sd67890, 32'd999999999, 32'd1000000000, -32'sd1000000000,
    32'd1234567890, 32'h7FFF_FFFF, 32'h8000_0001, 32'h8000_0000, 32'h7FFF_FFFE
  };

  signed_decimal_to_lcd_nibbles DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_push           (in_push),
    .in_full           (in_full),
    .in_value          (in_value),
    .out_empty         (out_empty),
    .out_pop           (out_pop),
    .out_nibble        (out_nibble),
    .out_final_transfer(out_final_transfer)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // offer one word until it is taken
  task automatic send_word(input logic [sdlcd_pkg::VALUE_WIDTH-1:0] v);
    in_push  <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (in_full);
    ledger.note_value(v);
  endtask

  // hold push low with noise on the value lines
  task automatic idle_input(input int n);
    in_push  <= 1'b0;
    in_value <= $urandom();
    repeat (n) @(posedge clk);
  endtask

  // random word: mix of full range, short, power-of-ten, bounded-digit and near-extreme values
  function automatic logic [31:0] pick_value();
    int          kind;
    int          d;
    logic [31:0] p;
    logic [31:0] v;
    kind = $urandom_range(0, 5);
    d    = $urandom_range(0, 9);
    p    = 32'd1;
    for (int i = 0; i < d; i++) p = p * 10;
    case (kind)
      0, 1: v = $urandom();
      2: v = $urandom_range(0, 200) - 100;
      3: v = p + $urandom_range(0, 2) - 1;
      4: v = (d == 9) ? $urandom() % 32'd2147483647 : $urandom() % (p * 10);
      default: begin
        if ($urandom_range(0, 1)) v = 32'h7FFF_FFFF - $urandom_range(0, 20);
        else v = 32'h8000_0000 + $urandom_range(0, 20);
      end
    endcase
    if (kind >= 2 && kind <= 4 && $urandom_range(0, 1)) v = -v;
    return v;
  endfunction

  // stimulus
  initial begin
    int idle_pct;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // corner words back to back, the receiver stall fills the block here
    foreach (corner_values[i]) send_word(corner_values[i]);

    // let everything drain before the random part
    in_push <= 1'b0;
    do @(posedge clk); while (ledger.pending() != 0);

    // random words, idling chosen per stretch of 20, none at the tail
    idle_pct = 0;
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n % 20 == 0) idle_pct = $urandom_range(0, 2) * 30;
      if (n >= RANDOM_WORDS - CALM_WORDS) begin
        calm = 1'b1;
        idle_pct = 0;
      end
      if ($urandom_range(0, 99) < idle_pct) idle_input($urandom_range(1, 11));
      send_word(pick_value());
    end
    in_push <= 1'b0;

    // wait for the stream to finish, then drain for strays
    while (ledger.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (ledger.errors == 0 && ledger.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // receiver: check popped nibbles, random stalls and one long hold-off
  initial begin
    int hold_left;
    int idle_pct;
    int window;
    int popped;
    bit long_hold_done;
    hold_left      = 0;
    idle_pct       = 0;
    window         = 0;
    popped         = 0;
    long_hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        ledger.check_nibble(out_nibble, out_final_transfer);
        popped++;
      end
      if (window == 0) begin
        idle_pct = $urandom_range(0, 2) * 25;
        window = 64;
      end
      window--;
      if (calm) idle_pct = 0;
      if (!long_hold_done && popped >= 60) begin
        long_hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end else if (hold_left == 0 && $urandom_range(0, 99) < idle_pct) begin
        hold_left = $urandom_range(1, 11);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n;
      end
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

endmodule
